// ===== rtl/glcd_pkg.sv =====
// Shared types and constants for the graphic LCD frame buffer.
// Holds the item payload structs, the operation codes and the LCD bus codes.
// No dependencies.
package glcd_pkg;

  // Default geometry of the panel and the font
  localparam int COLUMNS_DEF     = 128;
  localparam int PAGES_DEF       = 8;
  localparam int GLYPH_WIDTH_DEF = 5;
  localparam int GLYPH_COUNT_DEF = 96;

  // LCD controller command and chip select codes
  localparam logic [7:0] CMD_SET_PAGE = 8'hB8;
  localparam logic [1:0] CS_LEFT      = 2'd1;
  localparam logic [1:0] CS_RIGHT     = 2'd2;
  localparam logic [1:0] CS_BOTH      = 2'd3;

  typedef enum logic [1:0] {
    OP_PUT_GLYPH    = 2'd0,
    OP_WRITE_BYTE   = 2'd1,
    OP_REFRESH_STEP = 2'd2,
    OP_NONE         = 2'd3
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] column;
    logic [2:0] page;
    logic [6:0] glyph_index;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] chip_select;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       frame_end;
  } out_item_t;

endpackage

// ===== rtl/glcd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module glcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/glcd_font.sv =====
// Built-in 5x8 font ROM: gives one column byte of a glyph, bit 0 the top pixel.
// Depends on glcd_pkg for the default glyph count.
module glcd_font
  import glcd_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic [6:0] glyph_index,
  input  logic [2:0] col_idx,
  output logic [7:0] col_byte
);

  localparam int FONT_ROWS = 96;
  localparam int FONT_COLS = 5;

  // Each entry lists columns 0 to 4 from the most significant byte down
  localparam logic [39:0] FONT [FONT_ROWS] = '{
    40'h00_00_00_00_00, 40'h00_00_4f_00_00, 40'h00_07_00_07_00, 40'h14_7f_14_7f_14,
    40'h24_2a_7f_2a_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1c_22_41_00, 40'h00_41_22_1c_00, 40'h14_08_3e_08_14, 40'h08_08_3e_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3e_51_49_45_3e, 40'h00_42_7f_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4b_31,
    40'h18_14_12_7f_10, 40'h27_45_45_45_39, 40'h3c_4a_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1e, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3e, 40'h7e_11_11_11_7e, 40'h7f_49_49_49_36, 40'h3e_41_41_41_22,
    40'h7f_41_41_22_1c, 40'h7f_49_49_49_41, 40'h7f_09_09_09_01, 40'h3e_41_49_49_7a,
    40'h7f_08_08_08_7f, 40'h00_41_7f_41_00, 40'h20_40_41_3f_01, 40'h7f_08_14_22_41,
    40'h7f_40_40_40_40, 40'h7f_02_0c_02_7f, 40'h7f_04_08_10_7f, 40'h3e_41_41_41_3e,
    40'h7f_09_09_09_06, 40'h3e_41_51_21_5e, 40'h7f_09_19_29_46, 40'h26_49_49_49_32,
    40'h01_01_7f_01_01, 40'h3f_40_40_40_3f, 40'h1f_20_40_20_1f, 40'h3f_40_38_40_3f,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7f_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7f_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7f_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7f, 40'h38_54_54_54_18, 40'h08_7e_09_01_02, 40'h0c_52_52_52_3e,
    40'h7f_08_04_04_78, 40'h00_04_7d_00_00, 40'h20_40_44_3d_00, 40'h7f_10_28_44_00,
    40'h00_41_7f_40_00, 40'h7c_04_18_04_7c, 40'h7c_08_04_04_78, 40'h38_44_44_44_38,
    40'h7c_14_14_14_08, 40'h08_14_14_18_7c, 40'h7c_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3f_44_40_20, 40'h3c_40_40_20_7c, 40'h1c_20_40_20_1c, 40'h3c_40_30_40_3c,
    40'h44_28_10_28_44, 40'h0c_50_50_50_3c, 40'h44_64_54_4c_44, 40'h00_08_36_41_00,
    40'h00_00_77_00_00, 40'h00_41_36_08_00, 40'h08_04_08_10_08, 40'h00_00_00_00_00
  };

  logic [39:0] row;
  logic        blank;

  // Blank out glyphs past the font and columns past the fifth
  assign blank = (32'(glyph_index) >= GLYPH_COUNT) || (32'(glyph_index) >= FONT_ROWS) ||
                 (32'(col_idx) >= FONT_COLS);
  assign row   = blank ? '0 : FONT[glyph_index];

  // Pick the column byte
  always_comb begin
    unique case (col_idx)
      3'd0:    col_byte = row[39:32];
      3'd1:    col_byte = row[31:24];
      3'd2:    col_byte = row[23:16];
      3'd3:    col_byte = row[15:8];
      3'd4:    col_byte = row[7:0];
      default: col_byte = '0;
    endcase
  end

endmodule

// ===== rtl/glcd_text_framebuffer_refresh.sv =====
// Top level of the graphic LCD frame buffer with text font and scan-out.
// Depends on glcd_pkg, glcd_ram (buffer memory) and glcd_font (glyph ROM).
//
// Usage:
//   Items enter on in_item, accepted when start is high and busy is low.
//   put_glyph writes GLYPH_WIDTH font columns, write_byte one byte, and
//   refresh_step yields one LCD bus beat on out_item, marked by out_strobe
//   for exactly one cycle. The receiver always takes the beat.
// Sequencing:
//   refresh_step with a set-page command due: beat in the cycle after accept,
//   busy stays low. refresh_step with a data byte: the buffer read is issued
//   at accept and the beat is registered from S_READ, with busy high there.
//   write_byte: busy through S_REDUCE and a single write in S_WRITE; put_glyph:
//   busy through S_REDUCE and GLYPH_WIDTH writes in S_WRITE. A starting address
//   past the buffer end keeps busy in S_REDUCE, one buffer size removed per step
//   (at most one with the default geometry); a glyph wrapping mid-write adds none.
//   The single write port of the buffer memory sets the glyph rate.
// Reset:
//   The buffer is cleared by a sweep over all COLUMNS*PAGES addresses (1024 by
//   default) with busy high; scan-out starts with the page 0 command.
module glcd_text_framebuffer_refresh
  import glcd_pkg::*;
#(
  parameter int COLUMNS     = COLUMNS_DEF,
  parameter int PAGES       = PAGES_DEF,
  parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF,
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int BUF_SIZE = COLUMNS * PAGES;
  localparam int AW       = $clog2(BUF_SIZE);
  localparam int LIN_MAX  = (7 * COLUMNS + 255 > BUF_SIZE) ? 7 * COLUMNS + 255 : BUF_SIZE;
  localparam int LIN_W    = $clog2(LIN_MAX + 1);
  localparam int CW       = $clog2(COLUMNS);
  localparam int PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int KW       = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int SPLIT    = COLUMNS / 2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_WRITE,
    S_READ
  } state_t;

  state_t          state_r, state_nxt;
  logic [LIN_W-1:0] lin_r, lin_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             is_glyph_r, is_glyph_nxt;
  logic [6:0]       idx_r, idx_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [PW-1:0]    scan_page_r, scan_page_nxt;
  logic [CW-1:0]    scan_col_r, scan_col_nxt;
  logic             cmd_due_r, cmd_due_nxt;
  logic [1:0]       pend_cs_r, pend_cs_nxt;
  logic             pend_end_r, pend_end_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;
  logic [7:0]       font_byte;
  logic [LIN_W-1:0] scan_lin;

  // Buffer memory
  glcd_ram #(
    .WIDTH (8),
    .DEPTH (BUF_SIZE)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Glyph column lookup
  glcd_font #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_font (
    .glyph_index (idx_r),
    .col_idx     (3'(k_r)),
    .col_byte    (font_byte)
  );

  // Scan-out read address, always inside the buffer
  assign scan_lin  = LIN_W'(scan_page_r) * LIN_W'(COLUMNS) + LIN_W'(scan_col_r);
  assign ram_raddr = scan_lin[AW-1:0];
  assign ram_waddr = lin_r[AW-1:0];

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Sequence clear sweep, writes and scan-out
  always_comb begin
    state_nxt      = state_r;
    lin_nxt        = lin_r;
    k_nxt          = k_r;
    is_glyph_nxt   = is_glyph_r;
    idx_nxt        = idx_r;
    byte_nxt       = byte_r;
    scan_page_nxt  = scan_page_r;
    scan_col_nxt   = scan_col_r;
    cmd_due_nxt    = cmd_due_r;
    pend_cs_nxt    = pend_cs_r;
    pend_end_nxt   = pend_end_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_wdata      = is_glyph_r ? font_byte : byte_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        lin_nxt   = lin_r + 1'b1;
        if (lin_r == LIN_W'(BUF_SIZE - 1)) begin
          lin_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          unique case (in_item.operation)
            OP_PUT_GLYPH, OP_WRITE_BYTE: begin
              lin_nxt      = LIN_W'(in_item.page) * LIN_W'(COLUMNS) + LIN_W'(in_item.column);
              k_nxt        = '0;
              is_glyph_nxt = (in_item.operation == OP_PUT_GLYPH);
              idx_nxt      = in_item.glyph_index;
              byte_nxt     = in_item.byte_value;
              state_nxt    = S_REDUCE;
            end
            OP_REFRESH_STEP: begin
              if (cmd_due_r) begin
                // Set-page command to both chips
                out_strobe_nxt           = 1'b1;
                out_item_nxt.chip_select = CS_BOTH;
                out_item_nxt.is_data     = 1'b0;
                out_item_nxt.bus_byte    = CMD_SET_PAGE + 8'(scan_page_r);
                out_item_nxt.frame_end   = 1'b0;
                cmd_due_nxt              = 1'b0;
                scan_col_nxt             = '0;
              end else begin
                // Read issued this cycle; advance the scan position
                pend_cs_nxt  = (32'(scan_col_r) < SPLIT) ? CS_LEFT : CS_RIGHT;
                pend_end_nxt = 1'b0;
                scan_col_nxt = scan_col_r + 1'b1;
                if (scan_col_r == CW'(COLUMNS - 1)) begin
                  scan_col_nxt = '0;
                  cmd_due_nxt  = 1'b1;
                  if (scan_page_r == PW'(PAGES - 1)) begin
                    pend_end_nxt  = 1'b1;
                    scan_page_nxt = '0;
                  end else begin
                    scan_page_nxt = scan_page_r + 1'b1;
                  end
                end
                state_nxt = S_READ;
              end
            end
            OP_NONE: begin
              state_nxt = S_IDLE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_REDUCE: begin
        // Drop one buffer size per cycle until the address is inside
        if (lin_r >= LIN_W'(BUF_SIZE)) begin
          lin_nxt = lin_r - LIN_W'(BUF_SIZE);
        end else begin
          state_nxt = S_WRITE;
        end
      end

      S_WRITE: begin
        ram_we  = 1'b1;
        k_nxt   = k_r + 1'b1;
        lin_nxt = (lin_r == LIN_W'(BUF_SIZE - 1)) ? '0 : lin_r + 1'b1;
        if (!is_glyph_r || (k_r == KW'(GLYPH_WIDTH - 1))) begin
          state_nxt = S_IDLE;
        end
      end

      S_READ: begin
        out_strobe_nxt           = 1'b1;
        out_item_nxt.chip_select = pend_cs_r;
        out_item_nxt.is_data     = 1'b1;
        out_item_nxt.bus_byte    = ram_rdata;
        out_item_nxt.frame_end   = pend_end_r;
        state_nxt                = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      lin_r        <= '0;
      scan_page_r  <= '0;
      scan_col_r   <= '0;
      cmd_due_r    <= 1'b1;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lin_r        <= lin_nxt;
      scan_page_r  <= scan_page_nxt;
      scan_col_r   <= scan_col_nxt;
      cmd_due_r    <= cmd_due_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    k_r        <= k_nxt;
    is_glyph_r <= is_glyph_nxt;
    idx_r      <= idx_nxt;
    byte_r     <= byte_nxt;
    pend_cs_r  <= pend_cs_nxt;
    pend_end_r <= pend_end_nxt;
    out_item_r <= out_item_nxt;
  end

  // A beat follows only a refresh accept or a buffer read
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == S_READ) ||
                   ($past(start) && !$past(busy) &&
                    ($past(in_item.operation) == OP_REFRESH_STEP)))
    else $error("result beat without a refresh step");

  // Frame end marks a right-chip data beat
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.frame_end) |-> (out_item.is_data && out_item.chip_select == CS_RIGHT))
    else $error("frame end on a non-data beat");

  // Buffer writes stay inside the buffer
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (lin_r < LIN_W'(BUF_SIZE)))
    else $error("buffer write address out of range");

  // The clear sweep writes zeros and keeps the block busy
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (busy && ram_we && ram_wdata == 8'd0))
    else $error("clear sweep misbehaves");

endmodule
